@@ sv/c4fm_pkg.sv @@
`default_nettype none

package c4fm_pkg;

  localparam int SAMPLES_PER_SYMBOL = 10;
  localparam int TAPS_PER_PHASE     = 8;
  localparam int LOWPASS_TAPS       = 10;
  localparam int SYMS_PER_BYTE      = 4;

  // lowpass history keeps one entry less than the tap count
  localparam int LP_HIST = LOWPASS_TAPS - 1;

  localparam int RC_LEN = 80;
  localparam int LP_LEN = 10;
  localparam int RC_IW  = $clog2(RC_LEN);
  localparam int LP_IW  = $clog2(LP_LEN);

  localparam int MAX_TAPS = (TAPS_PER_PHASE > LOWPASS_TAPS) ? TAPS_PER_PHASE : LOWPASS_TAPS;
  localparam int ACC_W    = 32 + $clog2(MAX_TAPS) + 1;
  localparam int CNT_W    = $clog2(MAX_TAPS);
  localparam int PH_W     = $clog2(SAMPLES_PER_SYMBOL);
  localparam int SYM_AW   = $clog2(TAPS_PER_PHASE);
  localparam int LP_AW    = (LP_HIST > 1) ? $clog2(LP_HIST) : 1;
  localparam int SYM_SW   = ((SYM_AW > CNT_W) ? SYM_AW : CNT_W) + 1;
  localparam int LP_SW    = ((LP_AW > CNT_W) ? LP_AW : CNT_W) + 1;
  localparam int SYMC_W   = $clog2(SYMS_PER_BYTE);

  localparam logic [1:0] DIBIT_P3 = 2'b11;
  localparam logic [1:0] DIBIT_P1 = 2'b10;
  localparam logic [1:0] DIBIT_M1 = 2'b00;
  localparam logic [1:0] DIBIT_M3 = 2'b01;

  localparam logic signed [15:0] LEVEL_P3 = 16'sd1260;
  localparam logic signed [15:0] LEVEL_P1 = 16'sd420;
  localparam logic signed [15:0] LEVEL_M1 = -16'sd420;
  localparam logic signed [15:0] LEVEL_M3 = -16'sd1260;

  localparam logic signed [15:0] SAT_POS = 16'sh7fff;
  localparam logic signed [15:0] SAT_NEG = 16'sh8000;

  localparam logic signed [15:0] RC_TABLE [RC_LEN] = '{
    -16'sd444, -16'sd897, -16'sd1311, -16'sd1636, -16'sd1825,
    -16'sd1840, -16'sd1659, -16'sd1278, -16'sd712, 16'sd0,
    16'sd800, 16'sd1613, 16'sd2354, 16'sd2936, 16'sd3277,
    16'sd3310, 16'sd2994, 16'sd2315, 16'sd1296, 16'sd0,
    -16'sd1478, -16'sd3011, -16'sd4448, -16'sd5627, -16'sd6386,
    -16'sd6580, -16'sd6090, -16'sd4839, -16'sd2800, 16'sd0,
    16'sd3474, 16'sd7482, 16'sd11835, 16'sd16311, 16'sd20666,
    16'sd24651, 16'sd28032, 16'sd30607, 16'sd32219, 16'sd32767,
    16'sd32219, 16'sd30607, 16'sd28032, 16'sd24651, 16'sd20666,
    16'sd16311, 16'sd11835, 16'sd7482, 16'sd3474, 16'sd0,
    -16'sd2800, -16'sd4839, -16'sd6090, -16'sd6580, -16'sd6386,
    -16'sd5627, -16'sd4448, -16'sd3011, -16'sd1478, 16'sd0,
    16'sd1296, 16'sd2315, 16'sd2994, 16'sd3310, 16'sd3277,
    16'sd2936, 16'sd2354, 16'sd1613, 16'sd800, 16'sd0,
    -16'sd712, -16'sd1278, -16'sd1659, -16'sd1840, -16'sd1825,
    -16'sd1636, -16'sd1311, -16'sd897, -16'sd444, 16'sd0
  };

  localparam logic signed [15:0] LP_TABLE [LP_LEN] = '{
    16'sd1294, -16'sd2251, 16'sd4312, -16'sd8402, 16'sd20999,
    16'sd20999, -16'sd8402, 16'sd4312, -16'sd2251, 16'sd1294
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYM,
    ST_RC,
    ST_RC_END,
    ST_SAT,
    ST_LP,
    ST_LP_END,
    ST_LP_X,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_SYM,
    SRC_LP,
    SRC_X
  } src_e;

  function automatic logic signed [15:0] rc_coef(input logic [PH_W-1:0] phase,
                                                 input logic [CNT_W-1:0] tap);
    int idx;
    idx = (SAMPLES_PER_SYMBOL - 1 - int'(phase)) + int'(tap) * SAMPLES_PER_SYMBOL;
    if (idx < RC_LEN) return RC_TABLE[idx[RC_IW-1:0]];
    return 16'sd0;
  endfunction

  function automatic logic signed [15:0] lp_coef(input int idx);
    if (idx < LP_LEN) return LP_TABLE[idx[LP_IW-1:0]];
    return 16'sd0;
  endfunction

  function automatic logic signed [15:0] level_of(input logic [1:0] dibit);
    logic signed [15:0] lvl;
    unique case (dibit)
      DIBIT_P3: lvl = LEVEL_P3;
      DIBIT_P1: lvl = LEVEL_P1;
      DIBIT_M1: lvl = LEVEL_M1;
      default:  lvl = LEVEL_M3;
    endcase
    return lvl;
  endfunction

  // shift right by 15 and clamp to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-31:0] hi;
    hi = acc[ACC_W-1:30];
    if ((&hi) || !(|hi)) return acc[30:15];
    return acc[ACC_W-1] ? SAT_NEG : SAT_POS;
  endfunction

endpackage

`default_nettype wire

@@ sv/c4fm_symbol_modulator.sv @@
// the first sample of a byte is registered from ST_EMIT, after the input transfer
//   passes through ST_SYM, ST_RC, ST_RC_END, ST_SAT, ST_LP, ST_LP_END and ST_LP_X;
//   samples come one at a time from the single shared multiply-accumulate walking both
//   history memories; ST_EMIT waits on output stall; new bytes are taken only in ST_IDLE
// reset clears the control state and the per-entry valid bits, so both histories read zero
`default_nettype none

module c4fm_symbol_modulator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [15:0] sample_o,
  output logic             last_o
);
  import c4fm_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [SYMC_W-1:0] sym_q, sym_d;
  logic [7:0]        byte_q, byte_d;
  logic [SYM_AW-1:0] sym_wp_q, sym_wp_d;
  logic [LP_AW-1:0]  lp_wp_q, lp_wp_d;
  logic signed [15:0] x_q, x_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // symbol history memory
  logic signed [15:0] sym_mem [TAPS_PER_PHASE];
  logic [TAPS_PER_PHASE-1:0] sym_vld_q;
  logic signed [15:0] sym_rdata_q;
  logic sym_rvld_q;
  logic sym_re, sym_we;
  logic [SYM_SW-1:0] sym_sum;
  logic [SYM_AW-1:0] sym_raddr;

  // lowpass history memory
  logic signed [15:0] lp_mem [LP_HIST];
  logic [LP_HIST-1:0] lp_vld_q;
  logic signed [15:0] lp_rdata_q;
  logic lp_rvld_q;
  logic lp_re, lp_we;
  logic [LP_SW-1:0] lp_sum;
  logic [LP_AW-1:0] lp_raddr;

  // multiply-accumulate stage, working in the cycle after the read issue
  logic mac_q, mac_d;
  src_e src_q, src_d;
  logic signed [15:0] coef_q, coef_d;
  logic signed [15:0] mac_op;
  logic signed [31:0] prod;
  logic acc_clr;

  logic out_vld_q, out_load, out_last, out_free;
  logic signed [15:0] sample_q;
  logic last_q;

  assign sym_sum   = SYM_SW'(sym_wp_q) + SYM_SW'(cnt_q);
  assign sym_raddr = (sym_sum >= SYM_SW'(TAPS_PER_PHASE)) ?
                     SYM_AW'(sym_sum - SYM_SW'(TAPS_PER_PHASE)) : SYM_AW'(sym_sum);
  assign lp_sum    = LP_SW'(lp_wp_q) + LP_SW'(cnt_q);
  assign lp_raddr  = (lp_sum >= LP_SW'(LP_HIST)) ?
                     LP_AW'(lp_sum - LP_SW'(LP_HIST)) : LP_AW'(lp_sum);

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    case (src_q)
      SRC_SYM: mac_op = sym_rvld_q ? sym_rdata_q : 16'sd0;
      SRC_LP:  mac_op = lp_rvld_q ? lp_rdata_q : 16'sd0;
      default: mac_op = x_q;
    endcase
  end

  assign prod = mac_op * coef_q;

  always_comb begin
    acc_d = acc_q;
    if (acc_clr) begin
      acc_d = '0;
    end else if (mac_q) begin
      acc_d = acc_q + ACC_W'(prod);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    sym_d    = sym_q;
    byte_d   = byte_q;
    sym_wp_d = sym_wp_q;
    lp_wp_d  = lp_wp_q;
    x_d      = x_q;
    mac_d    = 1'b0;
    src_d    = src_q;
    coef_d   = coef_q;
    sym_re   = 1'b0;
    sym_we   = 1'b0;
    lp_re    = 1'b0;
    lp_we    = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    out_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = data_byte_i;
          sym_d   = '0;
          state_d = ST_SYM;
        end
      end
      ST_SYM: begin
        sym_we   = 1'b1;
        sym_wp_d = (sym_wp_q == SYM_AW'(TAPS_PER_PHASE - 1)) ? '0 : sym_wp_q + 1'b1;
        byte_d   = byte_q << 2;
        phase_d  = '0;
        cnt_d    = '0;
        acc_clr  = 1'b1;
        state_d  = ST_RC;
      end
      ST_RC: begin
        sym_re = 1'b1;
        mac_d  = 1'b1;
        src_d  = SRC_SYM;
        coef_d = rc_coef(phase_q, cnt_q);
        if (cnt_q == CNT_W'(TAPS_PER_PHASE - 1)) begin
          cnt_d   = '0;
          state_d = ST_RC_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RC_END: begin
        state_d = ST_SAT;
      end
      ST_SAT: begin
        x_d     = sat16(acc_q);
        acc_clr = 1'b1;
        cnt_d   = '0;
        state_d = ST_LP;
      end
      ST_LP: begin
        lp_re  = 1'b1;
        mac_d  = 1'b1;
        src_d  = SRC_LP;
        coef_d = lp_coef(int'(cnt_q));
        if (cnt_q == CNT_W'(LP_HIST - 1)) begin
          cnt_d   = '0;
          state_d = ST_LP_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LP_END: begin
        // newest tap uses the fresh interpolator output
        mac_d   = 1'b1;
        src_d   = SRC_X;
        coef_d  = lp_coef(LOWPASS_TAPS - 1);
        state_d = ST_LP_X;
      end
      ST_LP_X: begin
        lp_we   = 1'b1;
        lp_wp_d = (lp_wp_q == LP_AW'(LP_HIST - 1)) ? '0 : lp_wp_q + 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = (sym_q == SYMC_W'(SYMS_PER_BYTE - 1)) &&
                     (phase_q == PH_W'(SAMPLES_PER_SYMBOL - 1));
          if (phase_q == PH_W'(SAMPLES_PER_SYMBOL - 1)) begin
            if (sym_q == SYMC_W'(SYMS_PER_BYTE - 1)) begin
              state_d = ST_IDLE;
            end else begin
              sym_d   = sym_q + 1'b1;
              state_d = ST_SYM;
            end
          end else begin
            phase_d = phase_q + 1'b1;
            cnt_d   = '0;
            acc_clr = 1'b1;
            state_d = ST_RC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      phase_q   <= '0;
      sym_q     <= '0;
      sym_wp_q  <= '0;
      lp_wp_q   <= '0;
      mac_q     <= 1'b0;
      src_q     <= SRC_SYM;
      acc_q     <= '0;
      sym_vld_q <= '0;
      lp_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      sym_q    <= sym_d;
      sym_wp_q <= sym_wp_d;
      lp_wp_q  <= lp_wp_d;
      mac_q    <= mac_d;
      src_q    <= src_d;
      acc_q    <= acc_d;
      if (sym_we) begin
        sym_vld_q[sym_wp_q] <= 1'b1;
      end
      if (lp_we) begin
        lp_vld_q[lp_wp_q] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    x_q    <= x_d;
    coef_q <= coef_d;
    if (out_load) begin
      sample_q <= sat16(acc_q);
      last_q   <= out_last;
    end
  end

  // registered-read memories; an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_wp_q] <= level_of(byte_q[7:6]);
    end
    if (sym_re) begin
      sym_rdata_q <= sym_mem[sym_raddr];
      sym_rvld_q  <= sym_vld_q[sym_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lp_we) begin
      lp_mem[lp_wp_q] <= x_q;
    end
    if (lp_re) begin
      lp_rdata_q <= lp_mem[lp_raddr];
      lp_rvld_q  <= lp_vld_q[lp_raddr];
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

  a_sat_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT || state_q == ST_EMIT) |-> !mac_q)
    else $error("accumulator still busy when its sum is taken");

  a_last_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last) |=> (state_q == ST_IDLE))
    else $error("final sample did not end the byte");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SYM && sym_q == '0))
    else $error("input transfer did not start the first symbol");

  // a stalled output transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(sample_o) && $stable(last_o)))
    else $error("stalled output transfer changed");

endmodule

`default_nettype wire
